[hw/rtl/weighted_exposure_tone_map_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the weighted exposure tone mapper
// Clocked checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_EXPOSURE_TONE_MAP_ASSERT_SVH
`define WEIGHTED_EXPOSURE_TONE_MAP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define WETM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define WETM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WETM_ASSERT(lbl, prop, msg)
`define WETM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/wetm_pkg.sv]
// ---------------------------------------------------------------------------
// wetm_pkg
// Types, constants and the gamma threshold table of the tone mapper.
// ---------------------------------------------------------------------------
package wetm_pkg;

  typedef struct packed {
    logic [31:0] red_sum;
    logic [31:0] green_sum;
    logic [31:0] blue_sum;
    logic [31:0] weight_sum;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_BIAS_RED   = 2'd0,
    REG_BIAS_GREEN = 2'd1,
    REG_BIAS_BLUE  = 2'd2
  } cfg_reg_t;

  localparam logic [15:0] BIAS_RED_RST   = 16'd655;
  localparam logic [15:0] BIAS_GREEN_RST = 16'd328;
  localparam logic [15:0] BIAS_BLUE_RST  = 16'd131;

  // quotient bits kept: everything at or above 8.0 clamps anyway
  localparam int DIV_BITS       = 20;
  localparam int LOW_BITS       = DIV_BITS - 16;
  localparam int DIV_STEPS      = 2;
  localparam int DIV_STAGES     = DIV_BITS / DIV_STEPS;
  localparam int SQ_STAGES      = 8;
  localparam int GAMMA_STAGES   = 8;
  localparam int EXPO_STAGES    = 7;
  localparam int LATENCY        = 1 + DIV_STAGES + 1 + EXPO_STAGES + SQ_STAGES + 1
                                  + GAMMA_STAGES;

  localparam logic [19:0] C_LIMIT    = 20'd524288;
  localparam logic [31:0] ONE_Q31    = 32'h8000_0000;
  localparam logic [31:0] RECIP5     = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
  localparam logic [29:0] EXPO_SCALE = 30'd1728;

  typedef logic [31:0] gamma_thr_t [256];

  localparam int BIGW = 264;

  // Smallest Q0.31 value v with v^5 * 510^11 >= (2k-1)^11 * 2^155, per k.
  function automatic gamma_thr_t build_gamma_thr();
    gamma_thr_t      tab;
    logic [BIGW-1:0] base510;
    logic [BIGW-1:0] rhs;
    logic [BIGW-1:0] lhs;
    logic [BIGW-1:0] pw;
    logic [32:0]     lo;
    logic [32:0]     hi;
    logic [32:0]     mid;
    base510 = BIGW'(1);
    for (int i = 0; i < 11; i++) base510 = base510 * BIGW'(510);
    tab[0] = '0;
    for (int k = 1; k < 256; k++) begin
      rhs = BIGW'(1);
      for (int i = 0; i < 11; i++) rhs = rhs * BIGW'(2 * k - 1);
      rhs = rhs << 155;
      lo  = '0;
      hi  = 33'h0_8000_0000;
      for (int it = 0; it < 34; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          pw  = BIGW'(mid);
          for (int i = 0; i < 4; i++) pw = pw * BIGW'(mid);
          lhs = pw * base510;
          if (lhs >= rhs) hi = mid;
          else lo = mid + 33'd1;
        end
      end
      tab[k] = lo[31:0];
    end
    return tab;
  endfunction

  localparam gamma_thr_t GAMMA_THR = build_gamma_thr();

endpackage

[hw/rtl/weighted_exposure_tone_map.sv]
// Stages from input transfer to output transfer, in order: capture, divider, mean color,
// exposure series, squaring, exposure value, gamma.
// Throughput: one pixel per cycle; a stalled output freezes the whole pipe.
// Reset: rst_n synchronous, clears all stage valid bits and loads bias defaults.
// ---------------------------------------------------------------------------
// weighted_exposure_tone_map
// Pixel tone mapper: mean color from splat sums, exposure curve, gamma 2.2.
// ---------------------------------------------------------------------------
`include "weighted_exposure_tone_map_assert.svh"

module weighted_exposure_tone_map (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wetm_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wetm_pkg::out_item_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import wetm_pkg::*;

  // Configuration registers
  logic [15:0] bias_red_r, bias_green_r, bias_blue_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_red_r   <= BIAS_RED_RST;
      bias_green_r <= BIAS_GREEN_RST;
      bias_blue_r  <= BIAS_BLUE_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_paddr[3:2]))
        REG_BIAS_RED:   bias_red_r   <= cfg_pwdata[15:0];
        REG_BIAS_GREEN: bias_green_r <= cfg_pwdata[15:0];
        REG_BIAS_BLUE:  bias_blue_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_reg_t'(cfg_paddr[3:2]))
      REG_BIAS_RED:   cfg_prdata = {16'd0, bias_red_r};
      REG_BIAS_GREEN: cfg_prdata = {16'd0, bias_green_r};
      REG_BIAS_BLUE:  cfg_prdata = {16'd0, bias_blue_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // Stage valid bits; advance everything unless the output is held
  logic [LATENCY-1:0] vld_r;
  logic [LATENCY-1:0] vld_nxt;
  logic               en;

  assign en       = !vld_r[LATENCY-1] || out_ready;
  assign in_ready = en;
  assign vld_nxt  = {vld_r[LATENCY-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= vld_nxt;
  end

  assign out_valid = vld_r[LATENCY-1];

  // Channel datapaths
  wetm_chan u_red (
    .clk    (clk),
    .en     (en),
    .sum    (in_data.red_sum),
    .weight (in_data.weight_sum),
    .bias   (bias_red_r),
    .result (out_data.red_out)
  );

  wetm_chan u_green (
    .clk    (clk),
    .en     (en),
    .sum    (in_data.green_sum),
    .weight (in_data.weight_sum),
    .bias   (bias_green_r),
    .result (out_data.green_out)
  );

  wetm_chan u_blue (
    .clk    (clk),
    .en     (en),
    .sum    (in_data.blue_sum),
    .weight (in_data.weight_sum),
    .bias   (bias_blue_r),
    .result (out_data.blue_out)
  );

  // Checks
  `WETM_ASSERT_NEXT(a_enter, in_valid && in_ready, vld_r[0], "accepted transfer did not enter")
  `WETM_ASSERT_NEXT(a_hold, !en, $stable(vld_r), "valid bits moved during a stall")
  `WETM_ASSERT(a_shift, en |=> (vld_r[LATENCY-1:1] == $past(vld_r[LATENCY-2:0])), "valid bits lost")

endmodule

[hw/rtl/wetm_chan.sv]
// ---------------------------------------------------------------------------
// wetm_chan
// One color channel: divide, add bias, exposure curve, gamma lookup.
// ---------------------------------------------------------------------------
module wetm_chan (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] sum,
  input  logic [31:0] weight,
  input  logic [15:0] bias,
  output logic [7:0]  result
);
  import wetm_pkg::*;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [32:0] div_step(logic [31:0] rem, logic [31:0] w, logic nb);
    logic [32:0] t;
    logic [32:0] d;
    t = {rem, nb};
    d = t - {1'b0, w};
    if (t >= {1'b0, w}) return {1'b1, d[31:0]};
    return {1'b0, t[31:0]};
  endfunction

  // dividend bit i of sum * 2^16 below the top part
  function automatic logic low_bit(logic [LOW_BITS-1:0] low, int i);
    logic b;
    b = 1'b0;
    for (int n = 0; n < LOW_BITS; n++) begin
      if (i == n + 16) b = low[n];
    end
    return b;
  endfunction

  // Divider pipeline
  logic [31:0]          rem_r  [DIV_STAGES+1];
  logic [31:0]          w_r    [DIV_STAGES+1];
  logic [DIV_BITS-1:0]  quo_r  [DIV_STAGES+1];
  logic [LOW_BITS-1:0]  low_r  [DIV_STAGES+1];
  logic                 zero_r [DIV_STAGES+1];
  logic                 sat_r  [DIV_STAGES+1];

  // capture the item, flag zero weight and quotient overflow
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {{LOW_BITS{1'b0}}, sum[31:LOW_BITS]};
      w_r[0]    <= weight;
      quo_r[0]  <= '0;
      low_r[0]  <= sum[LOW_BITS-1:0];
      zero_r[0] <= (weight == '0);
      sat_r[0]  <= ({{LOW_BITS{1'b0}}, sum} >= {weight, {LOW_BITS{1'b0}}});
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [31:0]         rem_nxt;
    logic [DIV_BITS-1:0] quo_nxt;
    logic [32:0]         st;

    // retire DIV_STEPS quotient bits
    always_comb begin
      rem_nxt = rem_r[j];
      quo_nxt = quo_r[j];
      st      = '0;
      for (int s = 0; s < DIV_STEPS; s++) begin
        st = div_step(rem_nxt, w_r[j], low_bit(low_r[j], DIV_BITS - 1 - j * DIV_STEPS - s));
        rem_nxt = st[31:0];
        quo_nxt[DIV_BITS - 1 - j * DIV_STEPS - s] = st[32];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= rem_nxt;
        w_r[j+1]    <= w_r[j];
        quo_r[j+1]  <= quo_nxt;
        low_r[j+1]  <= low_r[j];
        zero_r[j+1] <= zero_r[j];
        sat_r[j+1]  <= sat_r[j];
      end
    end
  end

  // Mean color with bias, limited to 8.0
  logic [DIV_BITS:0]   qv;
  logic [DIV_BITS+1:0] csum;
  logic [19:0]         c_nxt;
  logic [19:0]         c_r;

  always_comb begin
    if (zero_r[DIV_STAGES]) qv = '0;
    else if (sat_r[DIV_STAGES]) qv = {1'b1, {DIV_BITS{1'b0}}};
    else qv = {1'b0, quo_r[DIV_STAGES]};
    csum  = {1'b0, qv} + (DIV_BITS+2)'(bias);
    c_nxt = (csum > (DIV_BITS+2)'(C_LIMIT)) ? C_LIMIT : csum[19:0];
  end

  always_ff @(posedge clk) begin
    if (en) c_r <= c_nxt;
  end

  // Exposure argument z = c * 1728 / 5 and its powers
  logic [29:0] prod_r;
  logic [27:0] z_r, z_r3, z_r4, z_r5, z_r6;
  logic [24:0] z2_r4, z2_r5, z2_r6, z2_r7;
  logic [21:0] z3_r5;
  logic [18:0] z4_r6;
  logic [19:0] d3_r, d3_r6;
  logic [14:0] d4_r;
  logic [63:0] m5;
  logic [55:0] m_z2;
  logic [52:0] m_z3;
  logic [49:0] m_z4;
  logic [52:0] m_d3;
  logic [47:0] m_d4;
  logic [33:0] e_sum;

  always_comb begin
    m5    = 64'(prod_r) * 64'(RECIP5);
    m_z2  = 56'(z_r) * 56'(z_r);
    m_z3  = 53'(z2_r4) * 53'(z_r3);
    m_z4  = 50'(z3_r5) * 50'(z_r4);
    m_d3  = 53'(z3_r5[21:1]) * 53'(RECIP3);
    m_d4  = 48'(z4_r6[18:3]) * 48'(RECIP3);
    e_sum = 34'(ONE_Q31) + 34'(z2_r7[24:1]) + 34'(d4_r) - 34'(z_r6) - 34'(d3_r6);
  end

  logic [31:0] e_r [SQ_STAGES+1];

  // hold every series term until the slowest one, z^4 / 24, is ready
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 30'(c_r) * EXPO_SCALE;
      z_r    <= m5[61:34];
      z_r3   <= z_r;
      z2_r4  <= m_z2[55:31];
      z_r4   <= z_r3;
      z2_r5  <= z2_r4;
      z3_r5  <= m_z3[52:31];
      z_r5   <= z_r4;
      z2_r6  <= z2_r5;
      z4_r6  <= m_z4[49:31];
      z_r6   <= z_r5;
      d3_r   <= m_d3[52:33];
      z2_r7  <= z2_r6;
      d3_r6  <= d3_r;
      d4_r   <= m_d4[47:33];
      e_r[0] <= e_sum[31:0];
    end
  end

  // Eight rounded squarings raise the series to exp(-2.7c)
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    logic [63:0] sq;
    always_comb sq = 64'(e_r[k]) * 64'(e_r[k]) + 64'(32'h4000_0000);
    always_ff @(posedge clk) begin
      if (en) e_r[k+1] <= sq[62:31];
    end
  end

  // Exposure value and gamma search
  logic [31:0] v_r   [GAMMA_STAGES+1];
  logic [7:0]  acc_r [GAMMA_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]   <= ONE_Q31 - ((e_r[SQ_STAGES] > ONE_Q31) ? ONE_Q31 : e_r[SQ_STAGES]);
      acc_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < GAMMA_STAGES; g++) begin : g_gamma
    logic [7:0] cand;
    logic [7:0] acc_nxt;
    always_comb begin
      cand    = acc_r[g] | (8'h80 >> g);
      acc_nxt = (v_r[g] >= GAMMA_THR[cand]) ? cand : acc_r[g];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[g+1]   <= v_r[g];
        acc_r[g+1] <= acc_nxt;
      end
    end
  end

  assign result = acc_r[GAMMA_STAGES];

endmodule

[bench/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Testbench for weighted_exposure_tone_map. A behavioral tone curve predicts
// each pixel; results are checked in order against that queue of expected
// pixels while the input and output sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb;
  import wetm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = LATENCY + 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // bias copies used by the prediction
  logic [15:0] bias_r;
  logic [15:0] bias_g;
  logic [15:0] bias_b;

  out_item_t   pending_pixels[$];
  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_start;
  int          hold_cnt;
  int          quiet_cycles;

  weighted_exposure_tone_map u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Tone curve for one channel: mean color, exposure, gamma rounding
  function automatic logic [7:0] tone_channel(logic [31:0] sum, logic [31:0] wt,
                                              logic [15:0] bias);
    logic [63:0]  q;
    logic [63:0]  c;
    logic [63:0]  z;
    logic [63:0]  z2;
    logic [63:0]  z3;
    logic [63:0]  z4;
    logic [63:0]  e;
    logic [63:0]  v;
    logic [263:0] lhs;
    logic [263:0] rhs;
    int           lo;
    int           hi;
    int           mid;
    q = '0;
    if (wt != 0) begin
      q = ({32'b0, sum} << 16) / {32'b0, wt};
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    end
    c = q + {48'b0, bias};
    if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
    if (c > 64'd524288) c = 64'd524288;
    z  = c * 64'd1728 / 64'd5;
    z2 = (z * z) >> 31;
    z3 = (z2 * z) >> 31;
    z4 = (z3 * z) >> 31;
    e  = (64'h8000_0000 + z2 / 2 + z4 / 24) - (z + z3 / 6);
    for (int i = 0; i < 8; i++) e = (e * e + 64'h4000_0000) >> 31;
    if (e > 64'h8000_0000) e = 64'h8000_0000;
    v = 64'h8000_0000 - e;
    lhs = 264'd1;
    for (int i = 0; i < 5; i++) lhs = lhs * 264'(v);
    for (int i = 0; i < 11; i++) lhs = lhs * 264'd510;
    lo = 0;
    hi = 255;
    // largest code whose lower rounding edge is still reached
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      rhs = 264'd1;
      for (int i = 0; i < 11; i++) rhs = rhs * 264'(2 * mid - 1);
      rhs = rhs << 155;
      if (lhs >= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 8'(lo);
  endfunction

  function automatic out_item_t tone_pixel(in_item_t px);
    out_item_t r;
    r.red_out   = tone_channel(px.red_sum, px.weight_sum, bias_r);
    r.green_out = tone_channel(px.green_sum, px.weight_sum, bias_g);
    r.blue_out  = tone_channel(px.blue_sum, px.weight_sum, bias_b);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
    error_count++;
  endtask

  // Predict on input transfer, check on output transfer
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with nothing expected, red_out", 8'd0, out_data.red_out);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.red_out != want.red_out)
          report_mismatch("red_out", want.red_out, out_data.red_out);
        if (out_data.green_out != want.green_out)
          report_mismatch("green_out", want.green_out, out_data.green_out);
        if (out_data.blue_out != want.blue_out)
          report_mismatch("blue_out", want.blue_out, out_data.blue_out);
      end
    end
    if (rst_n && in_valid && in_ready) pending_pixels.push_back(tone_pixel(in_data));
  end

  // Receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_start) hold_cnt <= 400;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    out_ready <= !hold_start && hold_cnt <= 1 && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL weighted_exposure_tone_map");
      $finish;
    end
  end

  task automatic send_pixel(in_item_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait out every expected result
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] value);
    drain_pipe();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'($urandom_range(65535)), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    // only the low half of the data lands in a bias
    case (idx)
      REG_BIAS_RED:   bias_r = value;
      REG_BIAS_GREEN: bias_g = value;
      REG_BIAS_BLUE:  bias_b = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_biases(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    cfg_write(REG_BIAS_RED, r);
    cfg_write(REG_BIAS_GREEN, g);
    cfg_write(REG_BIAS_BLUE, b);
  endtask

  function automatic in_item_t px_of(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                                     logic [31:0] w);
    in_item_t p;
    p.red_sum = r;
    p.green_sum = g;
    p.blue_sum = b;
    p.weight_sum = w;
    return p;
  endfunction

  // Most sums spread the mean color over the live curve; some random, some zero weight
  function automatic in_item_t random_pixel();
    in_item_t   p;
    logic [63:0] s;
    int         kind;
    kind = $urandom_range(99);
    if (kind < 10) begin
      p = px_of($urandom, $urandom, $urandom, $urandom);
    end else if (kind < 16) begin
      p = px_of($urandom, $urandom, $urandom, 32'd0);
    end else begin
      p.weight_sum = (kind < 60) ? $urandom_range(1, 32'h0010_0000) : $urandom_range(1, 32'hFFFF_FFFF);
      s = (64'($urandom_range(0, 600000)) * p.weight_sum) >> 16;
      p.red_sum   = (s > 64'hFFFF_FFFF) ? $urandom : s[31:0];
      s = (64'($urandom_range(0, 600000)) * p.weight_sum) >> 16;
      p.green_sum = (s > 64'hFFFF_FFFF) ? $urandom : s[31:0];
      s = (64'($urandom_range(0, 600000)) * p.weight_sum) >> 16;
      p.blue_sum  = (s > 64'hFFFF_FFFF) ? $urandom : s[31:0];
    end
    return p;
  endfunction

  task automatic send_directed_set();
    send_pixel(px_of(32'd0, 32'd0, 32'd0, 32'd0));
    send_pixel(px_of(32'hFFFF_FFFF, 32'h1234_5678, 32'd1, 32'd0));
    send_pixel(px_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1));
    send_pixel(px_of(32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF));
    send_pixel(px_of(32'h0001_0000, 32'h0008_0000, 32'h0007_FFFF, 32'h0001_0000));
    send_pixel(px_of(32'h0000_8000, 32'h0000_4000, 32'h0000_1000, 32'h0001_0000));
    send_pixel(px_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_pixel(px_of(32'h0010_0000, 32'h0000_0001, 32'h0001_0000, 32'h0002_0000));
  endtask

  // Extremes of the fields and the special cases at reset biases
  task automatic test_directed();
    send_directed_set();
    drain_pipe();
  endtask

  // Bias extremes; the write to an unused address must change nothing
  task automatic test_bias_settings();
    set_biases(16'd0, 16'd0, 16'd0);
    send_directed_set();
    set_biases(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_directed_set();
    cfg_write(2'd3, 16'h0000);
    send_directed_set();
    set_biases(16'h5555, 16'hAAAA, 16'h0001);
    repeat (20) send_pixel(random_pixel());
    drain_pipe();
  endtask

  task automatic run_random(int count, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (count) send_pixel(random_pixel());
  endtask

  // Random pixels across the idling and stalling phases, biases changed between phases
  task automatic test_random_phases();
    run_random(450, 0, 0);
    set_biases(16'($urandom), 16'($urandom), 16'($urandom));
    run_random(450, 73, 0);
    set_biases(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
               16'($urandom_range(0, 2000)));
    run_random(450, 0, 73);
    set_biases(16'($urandom), 16'($urandom), 16'($urandom));
    run_random(450, 12, 12);
  endtask

  // Long receiver hold-off while pixels keep coming, then a full pause and more pixels
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    in_valid   <= 1'b0;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (100) send_pixel(random_pixel());
    drain_pipe();
    repeat (20) send_pixel(random_pixel());
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    hold_start  = 1'b0;
    hold_cnt    = 0;
    quiet_cycles = 0;
    error_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bias_r = BIAS_RED_RST;
    bias_g = BIAS_GREEN_RST;
    bias_b = BIAS_BLUE_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_bias_settings();
    test_random_phases();
    test_backpressure();
    drain_pipe();

    if (error_count == 0) begin
      $display("PASS weighted_exposure_tone_map");
    end else begin
      $display("FAIL weighted_exposure_tone_map");
    end
    $finish;
  end

endmodule
